[hdl/bfsa_pkg.sv]
// bfsa_pkg: shared types and constants for the bounded fifo server admission block
// used by bfsa_ctrl, bfsa_dp and bounded_fifo_server_admission_core; no dependencies
package bfsa_pkg;

    localparam int TIME_W  = 48;
    localparam int SVC_W   = 32;
    localparam int LIMIT_W = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd15;
    localparam logic [TIME_W-1:0]  TIME_MAX    = '1;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic retire;
        logic commit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic retire_ok;
        logic out_busy;
    } t_stat;

endpackage

[hdl/bfsa_ram.sv]
// bfsa_ram: generic single-write, single-read ram with registered read data
// no dependencies
module bfsa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bfsa_ctrl.sv]
// bfsa_ctrl: sequencer for one item: capture, read head, retire loop, commit
// depends on bfsa_pkg
module bfsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bfsa_pkg::t_stat i_stat,
    output bfsa_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_CHECK  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.retire  = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.retire_ok) begin
                    o_cmd.retire = 1'b1;
                    n_state      = S_READ;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[hdl/bfsa_dp.sv]
// bfsa_dp: finish-time ring, occupancy, admission test and output register
// depends on bfsa_pkg and bfsa_ram
module bfsa_dp #(
    parameter int MAX_WAITING = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfsa_pkg::t_cmd                i_cmd,
    output bfsa_pkg::t_stat               o_stat,
    input  logic [bfsa_pkg::LIMIT_W-1:0]  i_limit,
    input  logic [bfsa_pkg::TIME_W-1:0]   i_arrival,
    input  logic [bfsa_pkg::SVC_W-1:0]    i_service,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_accepted,
    output logic [bfsa_pkg::TIME_W-1:0]   o_finish
);

    localparam int DEPTH = MAX_WAITING + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int LW    = (CW > bfsa_pkg::LIMIT_W) ? CW : bfsa_pkg::LIMIT_W;
    localparam int TW    = bfsa_pkg::TIME_W;

    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [TW-1:0] r_latest;
    logic          r_out_valid;

    logic [TW-1:0]                r_arrival;
    logic [TW-1:0]                r_start;
    logic [bfsa_pkg::SVC_W-1:0]   r_service;
    logic                         r_accepted;
    logic [TW-1:0]                r_finish;

    logic [TW-1:0] ring_rdata;
    logic [TW:0]   sum;
    logic [TW-1:0] fin;
    logic [LW-1:0] eff_limit;
    logic [LW-1:0] waiting;
    logic          admit;
    logic          ring_we;

    bfsa_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_tail),
        .i_wdata (fin),
        .i_raddr (r_head),
        .o_rdata (ring_rdata)
    );

    // saturated finish time of the captured item
    assign sum = {1'b0, r_start} + (TW + 1)'(r_service);
    assign fin = sum[TW] ? bfsa_pkg::TIME_MAX : sum[TW-1:0];

    // admission against min(limit, capacity)
    assign eff_limit = (LW'(i_limit) > LW'(MAX_WAITING)) ? LW'(MAX_WAITING) : LW'(i_limit);
    assign waiting   = LW'(r_count - CW'(1));
    assign admit     = (r_count == '0) || (waiting < eff_limit);
    assign ring_we   = i_cmd.commit && admit;

    assign o_stat.retire_ok = (r_count != '0) && (ring_rdata <= r_arrival);
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_latest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.retire) begin
                r_head  <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                r_count <= r_count - CW'(1);
            end
            if (ring_we) begin
                r_tail   <= (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
                r_count  <= r_count + CW'(1);
                r_latest <= fin;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_arrival <= i_arrival;
            r_service <= i_service;
            r_start   <= (r_latest > i_arrival) ? r_latest : i_arrival;
        end
        if (i_cmd.commit) begin
            r_accepted <= admit;
            r_finish   <= admit ? fin : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_finish    = r_finish;

endmodule

[hdl/bounded_fifo_server_admission_core.sv]
// bounded_fifo_server_admission_core: single server fifo queue with tail drop
// result registered at commit, after capture, the head read and retire loop on the ring ram;
// commit waits while the output is stalled; a new item is taken only after the last commits
// reset: synchronous active low clears pointers, occupancy, last finish and output valid;
// queue_limit returns to 15; ring contents are not cleared and no clearing pass runs
// depends on bfsa_pkg, bfsa_ctrl, bfsa_dp, bfsa_ram
module bounded_fifo_server_admission_core #(
    parameter int MAX_WAITING = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // arrival_time[47:0], service_time[79:48]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // end_time[47:0]
    output logic        m_axis_tuser    // accepted
);

    logic [bfsa_pkg::LIMIT_W-1:0] r_limit;
    bfsa_pkg::t_cmd  cmd;
    bfsa_pkg::t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bfsa_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    bfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bfsa_dp #(
        .MAX_WAITING (MAX_WAITING)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_limit     (r_limit),
        .i_arrival   (s_axis_tdata[47:0]),
        .i_service   (s_axis_tdata[79:48]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_accepted  (m_axis_tuser),
        .o_finish    (m_axis_tdata)
    );

endmodule
